// ===== hdl/utf8_stream_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Concurrent check wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define UTF8SD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UTF8SD_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define UTF8SD_ASSERT(lbl, clk, rst, prop, msg)
`define UTF8SD_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== hdl/utf8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Controller states, command and status bundles, lead byte classification.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int CP_W  = 31;
  localparam int CNT_W = 3;

  localparam logic [1:0] CONT_TAG = 2'b10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_FRESH,
    ST_POST
  } ctl_state_t;

  typedef struct packed {
    logic use_in;
    logic latch;
    logic step_cont;
    logic step_fresh;
    logic emit_unwind;
    logic close_seq;
    logic idx_clear;
    logic idx_inc;
    logic last;
  } ctl_cmd_t;

  typedef struct packed {
    logic pending_nz;
    logic is_cont;
    logic opens;
    logic seq_end;
    logic completes;
    logic idx_at_end;
    logic out_free;
  } ctl_stat_t;

  typedef struct packed {
    logic             lead;
    logic [CNT_W-1:0] len;
    logic [7:0]       bits;
  } lead_info_t;

  function automatic lead_info_t classify_lead(input logic [7:0] b);
    lead_info_t r;
    r.lead = (b[7:6] == 2'b11) && (b[7:1] != 7'b1111111);
    if (b[7:5] == 3'b110) begin
      r.len  = 3'd2;
      r.bits = b & 8'h1f;
    end else if (b[7:4] == 4'b1110) begin
      r.len  = 3'd3;
      r.bits = b & 8'h0f;
    end else if (b[7:3] == 5'b11110) begin
      r.len  = 3'd4;
      r.bits = b & 8'h07;
    end else if (b[7:2] == 6'b111110) begin
      r.len  = 3'd5;
      r.bits = b & 8'h03;
    end else begin
      r.len  = 3'd6;
      r.bits = b & 8'h01;
    end
    return r;
  endfunction

endpackage

// ===== hdl/utf8sd_datapath.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder datapath
// Sequence state, held continuation bytes, unwind index and result register.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_top_macros.svh"

module utf8sd_datapath #(
  parameter int MAX_SEQ_BYTES = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  utf8sd_pkg::ctl_cmd_t        cmd,
  output utf8sd_pkg::ctl_stat_t       stat,
  input  logic [7:0]                  data_byte,
  input  logic                        stream_end,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [utf8sd_pkg::CP_W-1:0] code_point,
  output logic [utf8sd_pkg::CNT_W-1:0] byte_count,
  output logic                        invalid,
  output logic                        last_of_run
);
  import utf8sd_pkg::*;

  localparam int HD  = MAX_SEQ_BYTES - 2;
  localparam int HIW = (HD > 1) ? $clog2(HD) : 1;
  localparam int HCW = $clog2(HD + 1);
  localparam int PW  = $clog2(MAX_SEQ_BYTES);

  logic [PW-1:0]    pending_left;
  logic [7:0]       lead_value;
  logic [CP_W-1:0]  partial_code;
  logic [7:0]       held_bytes [HD];
  logic [HCW-1:0]   held_count;
  logic [CNT_W-1:0] seq_length;
  logic [HCW-1:0]   idx;
  logic [7:0]       cur_byte;
  logic             cur_end;

  logic [7:0]       b;
  logic             e;
  lead_info_t       li;
  logic             opens;
  logic [CP_W-1:0]  partial_next;
  logic [CNT_W-1:0] len_m1;
  logic [HCW-1:0]   idx_m1;
  logic             load;
  logic [CP_W-1:0]  cp_next;
  logic [CNT_W-1:0] cnt_next;
  logic             inv_next;

  assign b            = cmd.use_in ? data_byte : cur_byte;
  assign e            = cmd.use_in ? stream_end : cur_end;
  assign li           = classify_lead(b);
  assign opens        = li.lead && (li.len <= CNT_W'(MAX_SEQ_BYTES));
  assign partial_next = {partial_code[CP_W-7:0], b[5:0]};
  assign len_m1       = li.len - 3'd1;
  assign idx_m1       = idx - HCW'(1);

  assign stat.pending_nz = (pending_left != '0);
  assign stat.is_cont    = (b[7:6] == CONT_TAG);
  assign stat.opens      = opens;
  assign stat.seq_end    = e;
  assign stat.completes  = (pending_left == PW'(1));
  assign stat.idx_at_end = (idx == held_count);
  assign stat.out_free   = !result_valid || result_ready;

  always_comb begin
    load     = 1'b0;
    cp_next  = '0;
    cnt_next = 3'd1;
    inv_next = 1'b1;
    priority if (cmd.emit_unwind) begin
      load    = 1'b1;
      cp_next = (idx == '0) ? CP_W'(lead_value) : CP_W'(held_bytes[idx_m1[HIW-1:0]]);
    end else if (cmd.step_cont && stat.completes) begin
      load     = 1'b1;
      cp_next  = partial_next;
      cnt_next = seq_length;
      inv_next = 1'b0;
    end else if (cmd.step_fresh && !opens) begin
      load     = 1'b1;
      cp_next  = CP_W'(b);
      inv_next = b[7];
    end else begin
      load = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_left <= '0;
      lead_value   <= '0;
      partial_code <= '0;
      held_count   <= '0;
      seq_length   <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      priority if (cmd.close_seq || (cmd.step_cont && stat.completes)) begin
        pending_left <= '0;
        lead_value   <= '0;
        partial_code <= '0;
        held_count   <= '0;
        seq_length   <= '0;
      end else if (cmd.step_cont) begin
        partial_code <= partial_next;
        pending_left <= pending_left - PW'(1);
        held_count   <= held_count + HCW'(1);
      end else if (cmd.step_fresh && opens) begin
        lead_value   <= b;
        partial_code <= CP_W'(li.bits);
        pending_left <= len_m1[PW-1:0];
        seq_length   <= li.len;
        held_count   <= '0;
      end else begin
        pending_left <= pending_left;
      end
      priority if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + HCW'(1);
      end else begin
        idx <= idx;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_cont && !stat.completes) begin
      held_bytes[held_count[HIW-1:0]] <= b;
    end
    if (cmd.latch) begin
      cur_byte <= data_byte;
      cur_end  <= stream_end;
    end
    if (load) begin
      code_point  <= cp_next;
      byte_count  <= cnt_next;
      invalid     <= inv_next;
      last_of_run <= cmd.last;
    end
  end

  `UTF8SD_NEVER(a_no_overwrite, clk, rst,
                load && result_valid && !result_ready, "result overwritten while stalled")
  `UTF8SD_ASSERT(a_seq_len, clk, rst,
                 (pending_left != '0) |->
                   (seq_length == 3'(pending_left) + 3'(held_count) + 3'd1),
                 "sequence length out of step")
  `UTF8SD_ASSERT(a_closed, clk, rst,
                 (pending_left == '0) |-> ((held_count == '0) && (seq_length == '0)),
                 "closed sequence holds bytes")

endmodule

// ===== hdl/utf8sd_ctrl.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder controller
// Steps an item through accept, pre-unwind, fresh decode and end unwind.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_top_macros.svh"

module utf8sd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  utf8sd_pkg::ctl_stat_t stat,
  output utf8sd_pkg::ctl_cmd_t  cmd
);
  import utf8sd_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    byte_ready = (state == ST_IDLE) && stat.out_free;
    unique case (state)
      ST_IDLE: begin
        cmd.use_in = 1'b1;
        if (byte_valid && stat.out_free) begin
          cmd.idx_clear = 1'b1;
          priority if (stat.pending_nz && !stat.is_cont) begin
            cmd.latch  = 1'b1;
            state_next = ST_PRE;
          end else if (stat.pending_nz) begin
            cmd.step_cont = 1'b1;
            cmd.last      = 1'b1;
            if (!stat.completes && stat.seq_end) begin
              state_next = ST_POST;
            end
          end else begin
            cmd.step_fresh = 1'b1;
            cmd.last       = 1'b1;
            if (stat.opens && stat.seq_end) begin
              state_next = ST_POST;
            end
          end
        end
      end
      ST_PRE: begin
        if (stat.out_free) begin
          cmd.emit_unwind = 1'b1;
          cmd.last        = stat.idx_at_end && stat.opens && !stat.seq_end;
          if (stat.idx_at_end) begin
            cmd.close_seq = 1'b1;
            state_next    = ST_FRESH;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ST_FRESH: begin
        if (stat.out_free) begin
          cmd.step_fresh = 1'b1;
          cmd.last       = 1'b1;
          cmd.idx_clear  = 1'b1;
          state_next     = (stat.opens && stat.seq_end) ? ST_POST : ST_IDLE;
        end
      end
      ST_POST: begin
        if (stat.out_free) begin
          cmd.emit_unwind = 1'b1;
          cmd.last        = stat.idx_at_end;
          if (stat.idx_at_end) begin
            cmd.close_seq = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
    endcase
  end

  `UTF8SD_ASSERT(a_pre_open, clk, rst, (state == ST_PRE) |-> stat.pending_nz, "pre-unwind without open sequence")
  `UTF8SD_ASSERT(a_post_open, clk, rst, (state == ST_POST) |-> stat.pending_nz, "end unwind without open sequence")
  `UTF8SD_ASSERT(a_fresh_closed, clk, rst, (state == ST_FRESH) |-> !stat.pending_nz, "fresh decode with sequence still open")

endmodule

// ===== hdl/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder (six-byte form, code points up to 31 bits).
// Input channel byte_valid/byte_ready carries one raw byte (data_byte) and
// stream_end, set on the last byte of a stream. Output channel
// result_valid/result_ready carries code_point, byte_count, invalid and
// last_of_run; last_of_run marks the final result caused by one byte.
// A byte that is ASCII, an error or the final continuation of a sequence
// yields its result in the cycle after acceptance, and bytes that open or
// extend a sequence are taken back to back, one byte per cycle while the
// result register is free. A byte that breaks an open sequence first
// releases the lead and every held continuation as one-byte errors, one
// result per cycle while the receiver takes them, then is decoded itself.
// A stream end with a sequence still open releases it as one-byte errors
// too. Input is taken only while the result register is empty or draining.
// When the receiver stalls, the result register holds and the controller
// waits. Reset clears the open sequence and drops any pending result.
// ----------------------------------------------------------------------------
// UTF-8 stream decoder top level
// Controller and datapath joined by command and status bundles.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top #(
  parameter int MAX_SEQ_BYTES = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_valid,
  output logic                         byte_ready,
  input  logic [7:0]                   data_byte,
  input  logic                         stream_end,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [utf8sd_pkg::CP_W-1:0]  code_point,
  output logic [utf8sd_pkg::CNT_W-1:0] byte_count,
  output logic                         invalid,
  output logic                         last_of_run
);
  import utf8sd_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  utf8sd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  utf8sd_datapath #(
    .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .data_byte    (data_byte),
    .stream_end   (stream_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .code_point   (code_point),
    .byte_count   (byte_count),
    .invalid      (invalid),
    .last_of_run  (last_of_run)
  );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives raw bytes through the six-byte UTF-8 decoder with random idling on
// both handshakes, predicts every decoded code point and error run, and
// checks each result field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8sd_pkg::*;

  localparam int MAX_SEQ_BYTES = 6;
  localparam int RANDOM_ITEMS  = 95;
  localparam int IDLE_PCT      = 14;
  localparam int LONG_STALL    = 80;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       hold_for_drain;
  } byte_item_t;

  typedef struct {
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] byte_count;
    logic             invalid;
    logic             last_of_run;
  } decoded_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             byte_valid = 1'b0;
  logic             byte_ready;
  logic [7:0]       data_byte = 8'h00;
  logic             stream_end = 1'b0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  logic [CP_W-1:0]  code_point;
  logic [CNT_W-1:0] byte_count;
  logic             invalid;
  logic             last_of_run;

  byte_item_t byte_queue[$];
  decoded_t   expected_results[$];
  decoded_t   run_results[$];
  int         total_items;
  int         items_accepted = 0;
  int         pending_results = 0;
  int         errors = 0;
  int         stall_left = 0;
  bit         stall_done = 1'b0;

  logic [2:0]      seq_left = '0;
  logic [7:0]      seq_lead = '0;
  logic [CP_W-1:0] seq_code = '0;
  logic [7:0]      seq_held[4];
  logic [2:0]      seq_held_n = '0;
  logic [2:0]      seq_len = '0;

  utf8_stream_decoder_top #(
    .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .data_byte(data_byte),
    .stream_end(stream_end),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .code_point(code_point),
    .byte_count(byte_count),
    .invalid(invalid),
    .last_of_run(last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void add_result(logic [CP_W-1:0] cp, logic [CNT_W-1:0] cnt, logic bad);
    decoded_t r;
    r.code_point  = cp;
    r.byte_count  = cnt;
    r.invalid     = bad;
    r.last_of_run = 1'b0;
    run_results.push_back(r);
  endfunction

  function automatic void unwind_open_seq();
    add_result(CP_W'(seq_lead), 3'd1, 1'b1);
    for (int j = 0; j < seq_held_n && j < 4; j++)
      add_result(CP_W'(seq_held[j]), 3'd1, 1'b1);
    seq_left   = '0;
    seq_lead   = '0;
    seq_code   = '0;
    seq_held_n = '0;
    seq_len    = '0;
  endfunction

  function automatic int decode_byte(logic [7:0] b, logic at_end);
    logic       consumed;
    logic [2:0] len;
    logic [7:0] bits;
    int         n;
    run_results.delete();
    consumed = 1'b0;
    if (seq_left != 0) begin
      if (b[7:6] == CONT_TAG) begin
        seq_code = (seq_code << 6) | CP_W'(b[5:0]);
        seq_left = seq_left - 3'd1;
        if (seq_left == 0) begin
          add_result(seq_code, seq_len, 1'b0);
          seq_lead   = '0;
          seq_code   = '0;
          seq_held_n = '0;
          seq_len    = '0;
        end else begin
          seq_held[seq_held_n[1:0]] = b;
          if (seq_held_n < 4) seq_held_n = seq_held_n + 3'd1;
        end
        consumed = 1'b1;
      end else begin
        unwind_open_seq();
      end
    end
    if (!consumed) begin
      if (b < 8'h80) begin
        add_result(CP_W'(b), 3'd1, 1'b0);
      end else if (b < 8'hc0 || b >= 8'hfe) begin
        add_result(CP_W'(b), 3'd1, 1'b1);
      end else begin
        if (b < 8'he0) begin
          len = 3'd2; bits = b & 8'h1f;
        end else if (b < 8'hf0) begin
          len = 3'd3; bits = b & 8'h0f;
        end else if (b < 8'hf8) begin
          len = 3'd4; bits = b & 8'h07;
        end else if (b < 8'hfc) begin
          len = 3'd5; bits = b & 8'h03;
        end else begin
          len = 3'd6; bits = b & 8'h01;
        end
        if (len > MAX_SEQ_BYTES) begin
          add_result(CP_W'(b), 3'd1, 1'b1);
        end else begin
          seq_lead   = b;
          seq_code   = CP_W'(bits);
          seq_left   = len - 3'd1;
          seq_len    = len;
          seq_held_n = '0;
        end
      end
    end
    if (at_end && seq_left != 0) unwind_open_seq();
    n = run_results.size();
    if (n > 0) run_results[n-1].last_of_run = 1'b1;
    foreach (run_results[i]) expected_results.push_back(run_results[i]);
    return n;
  endfunction

  function automatic void add_byte(logic [7:0] b, logic e);
    byte_item_t it;
    it.data = b;
    it.last = e;
    it.hold_for_drain = (byte_queue.size() == 25 || byte_queue.size() == 95);
    byte_queue.push_back(it);
  endfunction

  function automatic logic [7:0] rand_lead(int len);
    case (len)
      1:       return 8'($urandom_range(0, 8'h7f));
      2:       return 8'hc0 | 8'($urandom_range(0, 8'h1f));
      3:       return 8'he0 | 8'($urandom_range(0, 8'h0f));
      4:       return 8'hf0 | 8'($urandom_range(0, 8'h07));
      5:       return 8'hf8 | 8'($urandom_range(0, 8'h03));
      default: return 8'hfc | 8'($urandom_range(0, 8'h01));
    endcase
  endfunction

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 8'h3f));
  endfunction

  function automatic logic rand_end(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit no_idle_window();
    return items_accepted >= 70 && items_accepted < 105;
  endfunction

  always @(posedge clk) begin
    byte_item_t it;
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_ready) begin
      if (byte_queue.size() != 0 &&
          !(byte_queue[0].hold_for_drain && (byte_valid || pending_results != 0)) &&
          (no_idle_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
        it = byte_queue.pop_front();
        byte_valid <= 1'b1;
        data_byte  <= it.data;
        stream_end <= it.last;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (!stall_done && items_accepted >= 50) begin
      stall_done = 1'b1;
      stall_left = LONG_STALL;
      result_ready <= 1'b0;
    end else begin
      result_ready <= no_idle_window() || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    int       n;
    decoded_t want;
    if (!rst) begin
      n = pending_results;
      if (byte_valid && byte_ready) begin
        n += decode_byte(data_byte, stream_end);
        items_accepted <= items_accepted + 1;
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: code_point %h byte_count %0d invalid %b",
                 code_point, byte_count, invalid);
          errors++;
        end else begin
          want = expected_results.pop_front();
          n--;
          if (code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, code_point);
            errors++;
          end
          if (byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, byte_count);
            errors++;
          end
          if (invalid !== want.invalid) begin
            $error("invalid: expected %b, got %b", want.invalid, invalid);
            errors++;
          end
          if (last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, last_of_run);
            errors++;
          end
        end
      end
      pending_results <= n;
    end
  end

  initial begin
    int kind;
    int len;
    int conts;
    logic [7:0] b;

    add_byte(8'h00, 1'b0);
    add_byte(8'h7f, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hfe, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'hc2, 1'b0);
    add_byte(8'ha9, 1'b0);
    add_byte(8'hfd, 1'b0);
    repeat (5) add_byte(8'hbf, 1'b0);
    add_byte(8'hf8, 1'b0);
    add_byte(8'h88, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'hfc, 1'b0);
    repeat (4) add_byte(8'h80, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'he0, 1'b0);
    add_byte(8'h80, 1'b1);

    total_items = byte_queue.size() + RANDOM_ITEMS;
    while (byte_queue.size() < total_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = $urandom_range(1, 6);
        add_byte(rand_lead(len), rand_end(3));
        for (int i = 1; i < len; i++) add_byte(rand_cont(), rand_end(3));
      end else if (kind < 75) begin
        len = $urandom_range(2, 6);
        conts = $urandom_range(0, len - 2);
        add_byte(rand_lead(len), 1'b0);
        repeat (conts) add_byte(rand_cont(), 1'b0);
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == CONT_TAG) b[6] = 1'b1;
        add_byte(b, rand_end(10));
      end else if (kind < 85) begin
        len = $urandom_range(2, 6);
        conts = $urandom_range(0, len - 2);
        add_byte(rand_lead(len), conts == 0);
        for (int i = 1; i <= conts; i++) add_byte(rand_cont(), i == conts);
      end else begin
        add_byte(8'($urandom_range(0, 255)), rand_end(10));
      end
    end
    total_items = byte_queue.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted != total_items || pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/utf8sd_pkg.sv
hdl/utf8sd_datapath.sv
hdl/utf8sd_ctrl.sv
hdl/utf8_stream_decoder_top.sv
sim/tb.sv
